[hdl/elffa_pkg.sv]
// ----------------------------------------------------------------------------
// elffa_pkg
// Shared constants, types and helpers for the free-list heap allocator.
// ----------------------------------------------------------------------------
package elffa_pkg;

  localparam int HEAP_WORDS_DEF = 4096;

  localparam logic [31:0] DSIZE     = 32'd8;
  localparam logic [31:0] MIN_BLOCK = 32'd16;
  localparam logic [31:0] FIRST_HDR = 32'd3;
  localparam logic [31:0] SIZE_MASK = ~32'h7;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NO_MEM  = 2'd2;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic  en;
    word_t addr;
    word_t data;
  } mem_wr_t;

  function automatic word_t hdr_of(input word_t off);
    return (off >> 2) - 32'd1;
  endfunction

endpackage

[hdl/elffa_heap_mem.sv]
// ----------------------------------------------------------------------------
// elffa_heap_mem
// Heap word store: one write and one registered read per cycle; accesses
// beyond the heap read as zero and writes there are dropped.
// ----------------------------------------------------------------------------
module elffa_heap_mem #(
  parameter int HEAP_WORDS = elffa_pkg::HEAP_WORDS_DEF
) (
  input  logic              clk,
  input  elffa_pkg::mem_wr_t wr,
  input  elffa_pkg::word_t   rd_addr,
  output elffa_pkg::word_t   rd_data
);
  import elffa_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);

  word_t mem [HEAP_WORDS];
  word_t q_r;
  logic  oob_r;

  logic wr_in, rd_in;

  assign wr_in = wr.addr < 32'(HEAP_WORDS);
  assign rd_in = rd_addr < 32'(HEAP_WORDS);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    q_r   <= mem[rd_addr[AW-1:0]];
    oob_r <= !rd_in;
  end

  assign rd_data = oob_r ? '0 : q_r;

endmodule

[hdl/explicit_list_first_fit_allocator_unit.sv]
// ----------------------------------------------------------------------------
// explicit_list_first_fit_allocator_unit
// Heap allocator with boundary tags and a doubly linked LIFO free list.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low: in_req_type selects
// allocate (in_req_size bytes) or free (in_block_addr). Exactly one result
// follows, shown for one cycle with out_valid high, on out_result_addr and
// out_status. The receiver cannot stall; the result register is loaded as the
// work ends, so busy drops in the cycle the strobe is shown.
// A zero-size allocate or a null or misaligned free is answered from idle, a
// free whose tags fail after its header or footer read. An allocate reads the
// header and link of each free-list node passed over and steps on; for the
// node that fits it reads the links, then unlinks and retags it or splits
// it. A walk that finds no fit ends at the check after the last node. A free
// reads and checks the tags, merges each free neighbour, then tags and pushes
// the block. Each step makes at most one heap memory access. After reset a
// clearing pass writes all HEAP_WORDS words with the initial prologue, free
// block and epilogue; busy is high meanwhile.
// ----------------------------------------------------------------------------
module explicit_list_first_fit_allocator_unit #(
  parameter int HEAP_WORDS = elffa_pkg::HEAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [13:0] in_req_size,
  input  logic [13:0] in_block_addr,
  output logic        out_valid,
  output logic [13:0] out_result_addr,
  output logic [1:0]  out_status
);
  import elffa_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int CW = $clog2(HEAP_WORDS / 4 + 2);
  localparam logic [31:0] AREA     = 32'(((HEAP_WORDS - 4) * 4) / 8 * 8);
  localparam logic [31:0] EPI      = FIRST_HDR + AREA / 4;
  localparam logic [31:0] FTR0     = FIRST_HDR + AREA / 4 - 32'd1;
  localparam logic [CW-1:0] WALK_MAX = CW'(HEAP_WORDS / 4);

  localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_A_CHK = 5'd2,
                         S_A_HD = 5'd3,  S_A_NX = 5'd4,  S_F_HD  = 5'd5,
                         S_F_FT = 5'd6,  S_F_PT = 5'd7,  S_F_NT  = 5'd8,
                         S_URNX = 5'd9,  S_URPV = 5'd10, S_UGET  = 5'd11,
                         S_UW1  = 5'd12, S_UW2  = 5'd13, S_TG0   = 5'd14,
                         S_TG1  = 5'd15, S_PU0  = 5'd16, S_PU1   = 5'd17,
                         S_PU2  = 5'd18, S_SP0  = 5'd19, S_SP1   = 5'd20,
                         S_SP2  = 5'd21, S_SP3  = 5'd22, S_SP4   = 5'd23,
                         S_SP5  = 5'd24, S_SP6  = 5'd25, S_SP7   = 5'd26;

  localparam logic [1:0] CTX_PLACE = 2'd0, CTX_NEXT = 2'd1, CTX_PREV = 2'd2;

  logic [4:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    ctx_r, ctx_nxt;
  word_t head_r, head_nxt, cur_r, cur_nxt, asize_r, asize_nxt, bsize_r, bsize_nxt;
  word_t h_r, h_nxt, uh_r, uh_nxt, nx_r, nx_nxt, pv_r, pv_nxt, hd_r, hd_nxt;
  word_t ptag_r, ptag_nxt, ntag_r, ntag_nxt, start_r, start_nxt, sz_r, sz_nxt;
  logic  pfree_r, pfree_nxt, talloc_r, talloc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [13:0] out_addr_r, out_addr_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  mem_wr_t wr;
  word_t   rd_addr, rdata;

  word_t rd_sz, roff, rem, psize, clr_w, tagv;
  logic  nfree_c, pfree_c;

  elffa_heap_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  assign rd_sz = rdata & SIZE_MASK;
  assign roff  = cur_r + asize_r;
  assign rem   = bsize_r - asize_r;
  assign psize = ptag_r & SIZE_MASK;
  assign clr_w = 32'(clr_r);
  assign tagv  = sz_r | 32'(talloc_r);
  assign pfree_c = !ptag_r[0] && psize >= MIN_BLOCK && h_r >= FIRST_HDR + psize / 4;
  assign nfree_c = !rdata[0] && rd_sz >= MIN_BLOCK &&
                   h_r + sz_r / 4 + rd_sz / 4 <= EPI;

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;       cnt_nxt = cnt_r;
    ctx_nxt = ctx_r;       head_nxt = head_r;     cur_nxt = cur_r;
    asize_nxt = asize_r;   bsize_nxt = bsize_r;   h_nxt = h_r;
    uh_nxt = uh_r;         nx_nxt = nx_r;         pv_nxt = pv_r;
    hd_nxt = hd_r;         ptag_nxt = ptag_r;     ntag_nxt = ntag_r;
    start_nxt = start_r;   sz_nxt = sz_r;         pfree_nxt = pfree_r;
    talloc_nxt = talloc_r;
    out_valid_nxt = 1'b0;  out_addr_nxt = out_addr_r;  out_status_nxt = out_status_r;
    wr = '0;
    rd_addr = '0;
    unique case (state_r)
      S_CLR: begin
        wr.en   = 1'b1;
        wr.addr = clr_w;
        if (clr_w == 32'd1 || clr_w == 32'd2) begin
          wr.data = DSIZE | 32'd1;
        end else if (clr_w == FIRST_HDR || clr_w == FTR0) begin
          wr.data = AREA;
        end else if (clr_w == EPI) begin
          wr.data = 32'd1;
        end else begin
          wr.data = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_w == 32'(HEAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          out_addr_nxt = '0;
          if (!in_req_type) begin
            if (in_req_size == '0) begin
              out_valid_nxt = 1'b1;  out_status_nxt = ST_IGNORED;
            end else begin
              asize_nxt = (in_req_size <= 14'd8) ? MIN_BLOCK :
                          ((32'(in_req_size) + 32'd15) & SIZE_MASK);
              cur_nxt   = head_r;
              cnt_nxt   = '0;
              state_nxt = S_A_CHK;
            end
          end else begin
            h_nxt   = hdr_of(32'(in_block_addr));
            rd_addr = hdr_of(32'(in_block_addr));
            if (in_block_addr != '0 && in_block_addr[2:0] == 3'd0 &&
                in_block_addr[13:2] >= 12'd4) begin
              state_nxt = S_F_HD;
            end else begin
              out_valid_nxt = 1'b1;  out_status_nxt = ST_IGNORED;
            end
          end
        end
      end
      S_A_CHK: begin
        rd_addr = hdr_of(cur_r);
        if (cnt_r > WALK_MAX || cur_r == '0) begin
          out_valid_nxt = 1'b1;  out_status_nxt = ST_NO_MEM;  out_addr_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_A_HD;
        end
      end
      S_A_HD: begin
        rd_addr = hdr_of(cur_r) + 32'd1;
        if (!rdata[0] && rd_sz >= asize_r) begin
          bsize_nxt = rd_sz;
          h_nxt     = hdr_of(cur_r);
          uh_nxt    = hdr_of(cur_r);
          ctx_nxt   = CTX_PLACE;
          state_nxt = S_URNX;
        end else begin
          state_nxt = S_A_NX;
        end
      end
      S_A_NX: begin
        cur_nxt   = rdata;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_A_CHK;
      end
      S_F_HD: begin
        hd_nxt  = rdata;
        sz_nxt  = rd_sz;
        rd_addr = h_r + rd_sz / 4 - 32'd1;
        if (rdata[0] && rd_sz >= MIN_BLOCK && h_r + rd_sz / 4 <= EPI) begin
          state_nxt = S_F_FT;
        end else begin
          out_valid_nxt = 1'b1;  out_status_nxt = ST_IGNORED;
          state_nxt = S_IDLE;
        end
      end
      S_F_FT: begin
        rd_addr = h_r - 32'd1;
        if (rdata == hd_r) begin
          state_nxt = S_F_PT;
        end else begin
          out_valid_nxt = 1'b1;  out_status_nxt = ST_IGNORED;
          state_nxt = S_IDLE;
        end
      end
      S_F_PT: begin
        ptag_nxt  = rdata;
        rd_addr   = h_r + sz_r / 4;
        state_nxt = S_F_NT;
      end
      S_F_NT: begin
        ntag_nxt   = rd_sz;
        pfree_nxt  = pfree_c;
        start_nxt  = h_r;
        talloc_nxt = 1'b0;
        if (nfree_c) begin
          uh_nxt = h_r + sz_r / 4;  ctx_nxt = CTX_NEXT;  state_nxt = S_URNX;
        end else if (pfree_c) begin
          start_nxt = h_r - psize / 4;  uh_nxt = h_r - psize / 4;
          ctx_nxt = CTX_PREV;  state_nxt = S_URNX;
        end else begin
          state_nxt = S_TG0;
        end
      end
      S_URNX: begin
        rd_addr = uh_r + 32'd1;  state_nxt = S_URPV;
      end
      S_URPV: begin
        nx_nxt = rdata;  rd_addr = uh_r + 32'd2;  state_nxt = S_UGET;
      end
      S_UGET: begin
        pv_nxt = rdata;
        state_nxt = (ctx_r == CTX_PLACE && rem >= MIN_BLOCK) ? S_SP0 : S_UW1;
      end
      S_UW1: begin
        if (pv_r == '0) begin
          head_nxt = nx_r;
        end else begin
          wr = '{en: 1'b1, addr: hdr_of(pv_r) + 32'd1, data: nx_r};
        end
        state_nxt = S_UW2;
      end
      S_UW2: begin
        wr = '{en: nx_r != '0, addr: hdr_of(nx_r) + 32'd2, data: pv_r};
        state_nxt = S_TG0;
        if (ctx_r == CTX_PLACE) begin
          start_nxt = h_r;  sz_nxt = bsize_r;  talloc_nxt = 1'b1;
        end else if (ctx_r == CTX_NEXT) begin
          sz_nxt = sz_r + ntag_r;
          if (pfree_r) begin
            start_nxt = h_r - psize / 4;  uh_nxt = h_r - psize / 4;
            ctx_nxt = CTX_PREV;  state_nxt = S_URNX;
          end
        end else begin
          sz_nxt = sz_r + psize;
        end
      end
      S_TG0: begin
        wr = '{en: 1'b1, addr: start_r, data: tagv};
        state_nxt = S_TG1;
      end
      S_TG1: begin
        wr = '{en: 1'b1, addr: start_r + sz_r / 4 - 32'd1, data: tagv};
        if (talloc_r) begin
          out_valid_nxt = 1'b1;  out_status_nxt = ST_DONE;  out_addr_nxt = cur_r[13:0];
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PU0;
        end
      end
      S_PU0: begin
        wr = '{en: 1'b1, addr: start_r + 32'd1, data: head_r};
        state_nxt = S_PU1;
      end
      S_PU1: begin
        wr = '{en: 1'b1, addr: start_r + 32'd2, data: '0};
        state_nxt = S_PU2;
      end
      S_PU2: begin
        wr = '{en: head_r != '0, addr: hdr_of(head_r) + 32'd2,
               data: (start_r + 32'd1) << 2};
        head_nxt = (start_r + 32'd1) << 2;
        out_valid_nxt = 1'b1;  out_status_nxt = ST_DONE;  out_addr_nxt = '0;
        state_nxt = S_IDLE;
      end
      S_SP0: begin
        wr = '{en: 1'b1, addr: h_r, data: asize_r | 32'd1};
        state_nxt = S_SP1;
      end
      S_SP1: begin
        wr = '{en: 1'b1, addr: h_r + asize_r / 4 - 32'd1, data: asize_r | 32'd1};
        state_nxt = S_SP2;
      end
      S_SP2: begin
        wr = '{en: 1'b1, addr: hdr_of(roff), data: rem};
        state_nxt = S_SP3;
      end
      S_SP3: begin
        wr = '{en: 1'b1, addr: hdr_of(roff) + rem / 4 - 32'd1, data: rem};
        state_nxt = S_SP4;
      end
      S_SP4: begin
        wr = '{en: 1'b1, addr: hdr_of(roff) + 32'd1, data: nx_r};
        state_nxt = S_SP5;
      end
      S_SP5: begin
        wr = '{en: 1'b1, addr: hdr_of(roff) + 32'd2, data: pv_r};
        state_nxt = S_SP6;
      end
      S_SP6: begin
        if (pv_r == '0) begin
          head_nxt = roff;
        end else begin
          wr = '{en: 1'b1, addr: hdr_of(pv_r) + 32'd1, data: roff};
        end
        state_nxt = S_SP7;
      end
      S_SP7: begin
        wr = '{en: nx_r != '0, addr: hdr_of(nx_r) + 32'd2, data: roff};
        out_valid_nxt = 1'b1;  out_status_nxt = ST_DONE;  out_addr_nxt = cur_r[13:0];
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      head_r      <= (FIRST_HDR + 32'd1) << 2;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;      ctx_r <= ctx_nxt;      cur_r <= cur_nxt;
    asize_r <= asize_nxt;  bsize_r <= bsize_nxt;  h_r <= h_nxt;
    uh_r <= uh_nxt;        nx_r <= nx_nxt;        pv_r <= pv_nxt;
    hd_r <= hd_nxt;        ptag_r <= ptag_nxt;    ntag_r <= ntag_nxt;
    start_r <= start_nxt;  sz_r <= sz_nxt;        pfree_r <= pfree_nxt;
    talloc_r <= talloc_nxt;
    out_addr_r <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("transfer neither started work nor answered");

  a_addr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_DONE || out_result_addr == '0)
    else $error("address shown with a failing status");

  a_quiet_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !out_valid && wr.en)
    else $error("clearing pass disturbed");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free-list heap allocator: a directed table of
// requests, then random allocate and free traffic checked against a local
// model of the heap words, tags and free list.
// ----------------------------------------------------------------------------
module tb;
  import elffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW       = HEAP_WORDS_DEF;
  localparam int AREA     = ((NW - 4) * 4) & ~7;
  localparam int EPI      = 3 + AREA / 4;
  localparam int WD_LIMIT = 4 * NW + 20000;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct {
    logic        kind;
    logic [13:0] size;
    logic [13:0] addr;
    logic        typed;
    logic [13:0] exp_addr;
    logic [1:0]  exp_status;
  } row_t;

  typedef struct {
    logic [13:0] addr;
    logic [1:0]  status;
  } reply_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        in_req_type = 0;
  logic [13:0] in_req_size = 0;
  logic [13:0] in_block_addr = 0;
  logic        busy, out_valid;
  logic [13:0] out_result_addr;
  logic [1:0]  out_status;

  explicit_list_first_fit_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_req_size(in_req_size),
    .in_block_addr(in_block_addr), .out_valid(out_valid),
    .out_result_addr(out_result_addr), .out_status(out_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  logic [31:0] heap_w [NW];
  logic [31:0] list_head;
  reply_t      replies_due[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic [13:0] live[$];

  function automatic logic [31:0] hrd(int unsigned w);
    return (w < NW) ? heap_w[w] : 32'd0;
  endfunction

  function automatic void hwr(int unsigned w, logic [31:0] v);
    if (w < NW) heap_w[w] = v;
  endfunction

  function automatic int unsigned hw(logic [31:0] off);
    return off / 4 - 1;
  endfunction

  function automatic void tag(int unsigned h, logic [31:0] sz, logic a);
    hwr(h, sz | a);
    hwr(h + sz / 4 - 1, sz | a);
  endfunction

  function automatic void heap_clear();
    for (int i = 0; i < NW; i++) heap_w[i] = 0;
    heap_w[1] = 9;
    heap_w[2] = 9;
    tag(3, AREA, 0);
    hwr(EPI, 1);
    list_head = 16;
  endfunction

  function automatic void unlink(logic [31:0] off);
    logic [31:0] nx, pv;
    nx = hrd(hw(off) + 1);
    pv = hrd(hw(off) + 2);
    if (pv == 0) list_head = nx;
    else hwr(hw(pv) + 1, nx);
    if (nx != 0) hwr(hw(nx) + 2, pv);
  endfunction

  function automatic void push(logic [31:0] off);
    hwr(hw(off) + 1, list_head);
    hwr(hw(off) + 2, 0);
    if (list_head != 0) hwr(hw(list_head) + 2, off);
    list_head = off;
  endfunction

  function automatic void carve(logic [31:0] off, logic [31:0] asz);
    int unsigned h, rh;
    logic [31:0] bsz, nx, pv, roff;
    h = hw(off);
    bsz = hrd(h) & SIZE_MASK;
    if (bsz - asz >= MIN_BLOCK) begin
      nx = hrd(h + 1);
      pv = hrd(h + 2);
      roff = off + asz;
      rh = hw(roff);
      tag(h, asz, 1);
      tag(rh, bsz - asz, 0);
      hwr(rh + 1, nx);
      hwr(rh + 2, pv);
      if (pv == 0) list_head = roff;
      else hwr(hw(pv) + 1, roff);
      if (nx != 0) hwr(hw(nx) + 2, roff);
    end else begin
      unlink(off);
      tag(h, bsz, 1);
    end
  endfunction

  function automatic void release_block(logic [31:0] off);
    int unsigned h, st;
    logic [31:0] sz, pt, ps, nt, ns;
    logic pf, nf;
    h = hw(off);
    sz = hrd(h) & SIZE_MASK;
    pt = hrd(h - 1);
    ps = pt & SIZE_MASK;
    nt = hrd(h + sz / 4);
    ns = nt & SIZE_MASK;
    pf = !pt[0] && ps >= MIN_BLOCK && h >= 3 + ps / 4;
    nf = !nt[0] && ns >= MIN_BLOCK && h + sz / 4 + ns / 4 <= EPI;
    st = h;
    if (nf) begin
      unlink((h + sz / 4 + 1) * 4);
      sz += ns;
    end
    if (pf) begin
      st = h - ps / 4;
      unlink((st + 1) * 4);
      sz += ps;
    end
    tag(st, sz, 0);
    push((st + 1) * 4);
  endfunction

  function automatic reply_t heap_request(logic kind, logic [13:0] rsz, logic [13:0] ra);
    reply_t r;
    logic [31:0] asz, cur, hd, a, s;
    int unsigned h;
    r.addr = 0;
    r.status = ST_IGNORED;
    if (kind == REQ_ALLOC) begin
      if (rsz != 0) begin
        asz = (rsz <= DSIZE) ? MIN_BLOCK : DSIZE * ((32'(rsz) + 15) / DSIZE);
        cur = list_head;
        r.status = ST_NO_MEM;
        for (int i = 0; i <= NW / 4 && cur != 0; i++) begin
          hd = hrd(hw(cur));
          if (!hd[0] && (hd & SIZE_MASK) >= asz) begin
            carve(cur, asz);
            r.addr = cur[13:0];
            r.status = ST_DONE;
            break;
          end
          cur = hrd(hw(cur) + 1);
        end
      end
    end else begin
      a = ra;
      if (a != 0 && a[2:0] == 0 && a / 4 >= 4) begin
        h = hw(a);
        hd = hrd(h);
        s = hd & SIZE_MASK;
        if (hd[0] && s >= MIN_BLOCK && h + s / 4 <= EPI && hrd(h + s / 4 - 1) == hd) begin
          release_block(a);
          r.status = ST_DONE;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%0d status=%0d",
                                       out_result_addr, out_status);
      end else begin
        e = replies_due.pop_front();
        if (e.addr !== out_result_addr || e.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr=%0d status=%0d, got addr=%0d status=%0d",
                     e.addr, e.status, out_result_addr, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("explicit_list_first_fit_allocator_unit regression: fail");
      $finish;
    end
  end

  task automatic send(logic kind, logic [13:0] rsz, logic [13:0] ra,
                      logic typed, logic [13:0] ea, logic [1:0] es);
    reply_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_req_type <= kind;
    in_req_size <= rsz;
    in_block_addr <= ra;
    do @(posedge clk); while (busy);
    p = heap_request(kind, rsz, ra);
    if (typed && (p.addr !== ea || p.status !== es)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row: exp addr=%0d status=%0d, model addr=%0d status=%0d",
                 ea, es, p.addr, p.status);
    end
    replies_due.push_back(p);
    if (kind == REQ_ALLOC && p.status == ST_DONE) live.push_back(p.addr);
  endtask

  row_t table_rows[$];

  initial begin
    int pick;
    logic [13:0] a;
    heap_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // directed: zero size, null, bad frees, extremes, coalesce cases
    table_rows = '{
      '{REQ_ALLOC, 14'd0, 14'd0, 1, 14'd0, ST_IGNORED},
      '{REQ_FREE, 14'd0, 14'd0, 1, 14'd0, ST_IGNORED},
      '{REQ_ALLOC, 14'd1, 14'd0, 1, 14'd16, ST_DONE},
      '{REQ_ALLOC, 14'd8, 14'd0, 1, 14'd32, ST_DONE},
      '{REQ_ALLOC, 14'd9, 14'd0, 0, 0, 0},
      '{REQ_ALLOC, 14'd100, 14'd0, 0, 0, 0},
      '{REQ_FREE, 14'd0, 14'd20, 1, 14'd0, ST_IGNORED},
      '{REQ_FREE, 14'd0, 14'd8, 1, 14'd0, ST_IGNORED},
      '{REQ_FREE, 14'd0, 14'h3ff8, 1, 14'd0, ST_IGNORED},
      '{REQ_FREE, 14'd0, 14'd32, 1, 14'd0, ST_DONE},
      '{REQ_FREE, 14'd0, 14'd32, 1, 14'd0, ST_IGNORED},
      '{REQ_FREE, 14'd0, 14'd16, 1, 14'd0, ST_DONE},
      '{REQ_ALLOC, 14'h3fff, 14'd0, 1, 14'd0, ST_NO_MEM},
      '{REQ_ALLOC, 14'd16360, 14'd0, 0, 0, 0},
      '{REQ_ALLOC, 14'd8, 14'd0, 0, 0, 0},
      '{REQ_FREE, 14'd0, 14'd72, 0, 0, 0},
      '{REQ_FREE, 14'd0, 14'd48, 0, 0, 0},
      '{REQ_FREE, 14'd0, 14'd16, 0, 0, 0},
      '{REQ_ALLOC, 14'd16368, 14'd0, 0, 0, 0},
      '{REQ_FREE, 14'd0, 14'd16, 0, 0, 0},
      '{REQ_FREE, 14'd0, 14'h3fff, 0, 0, 0}
    };
    foreach (table_rows[i])
      send(table_rows[i].kind, table_rows[i].size, table_rows[i].addr,
           table_rows[i].typed, table_rows[i].exp_addr, table_rows[i].exp_status);
    live.delete();
    for (int n = 0; n < 900; n++) begin
      if (n == 450) begin
        start <= 0;
        while (replies_due.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 19) == 0) send(REQ_ALLOC, 14'($urandom), 0, 0, 0, 0);
        else send(REQ_ALLOC, 14'($urandom_range(1, 600)), 14'($urandom), 0, 0, 0);
      end else if (pick < 85 && live.size() != 0) begin
        pick = $urandom_range(0, live.size() - 1);
        a = live[pick];
        live.delete(pick);
        send(REQ_FREE, 14'($urandom), a, 0, 0, 0);
      end else begin
        send(REQ_FREE, 14'($urandom), 14'($urandom), 0, 0, 0);
      end
    end
    start <= 0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("explicit_list_first_fit_allocator_unit regression: pass");
    else $display("explicit_list_first_fit_allocator_unit regression: fail");
    $finish;
  end
endmodule

[sim.f]
hdl/elffa_pkg.sv
hdl/elffa_heap_mem.sv
hdl/explicit_list_first_fit_allocator_unit.sv
dv/tb.sv
